@@ rtl/dltm_pkg.sv @@
// Package: shared types, constants and helpers of the delta-list timer queue.
`timescale 1ns / 1ps
package dltm_pkg;

    localparam int SLOTS     = 16;
    localparam int MAX_FIRES = 63;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_STOP    = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [2:0] EV_CREATED  = 3'd0;
    localparam logic [2:0] EV_NO_SLOT  = 3'd1;
    localparam logic [2:0] EV_STOPPED  = 3'd2;
    localparam logic [2:0] EV_INACTIVE = 3'd3;
    localparam logic [2:0] EV_EXPIRED  = 3'd4;
    localparam logic [2:0] EV_DONE     = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] id;
        logic [31:0]       delta;
        logic [31:0]       period;
    } cell_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_SUB
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] pos;
        logic              fold;
        logic [SLOT_W-1:0] id;
        logic [31:0]       d;
        logic [31:0]       per;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_ADD,
        ST_WALK,
        ST_STOP,
        ST_ADV
    } state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/dltm_cell.sv @@
// One list cell: holds a slot handle, its delta and period, shifts with its neighbors.
`timescale 1ns / 1ps
module dltm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dltm_pkg::SLOT_W-1:0] idx,
    input  dltm_pkg::cell_cmd_t         cmd,
    input  dltm_pkg::cell_t             prev_cell,
    input  dltm_pkg::cell_t             next_cell,
    output dltm_pkg::cell_t             entry
);

    logic                        valid_reg;
    logic [dltm_pkg::SLOT_W-1:0] id_reg;
    logic [31:0]                 delta_reg;
    logic [31:0]                 period_reg;
    dltm_pkg::cell_t             cur;
    dltm_pkg::cell_t             cell_next;

    always_comb
    begin
        cur.valid  = valid_reg;
        cur.id     = id_reg;
        cur.delta  = delta_reg;
        cur.period = period_reg;
    end

    always_comb
    begin
        cell_next = cur;
        case (cmd.op)
            dltm_pkg::OP_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    cell_next.valid  = 1'b1;
                    cell_next.id     = cmd.id;
                    cell_next.delta  = cmd.d;
                    cell_next.period = cmd.per;
                end
                else if (idx > cmd.pos)
                begin
                    cell_next = prev_cell;
                    // first entry behind the new one gives up the inserted delta
                    if ({1'b0, idx} == {1'b0, cmd.pos} + 1'b1)
                        cell_next.delta = prev_cell.delta - cmd.d;
                end
            end
            dltm_pkg::OP_REMOVE:
            begin
                if (idx >= cmd.pos)
                begin
                    cell_next = next_cell;
                    if (idx == cmd.pos && cmd.fold && next_cell.valid)
                        cell_next.delta = dltm_pkg::sat_add(next_cell.delta, cur.delta);
                end
            end
            dltm_pkg::OP_SUB:
            begin
                if (idx == '0)
                    cell_next.delta = cur.delta - cmd.d;
            end
            default:
            begin
                cell_next = cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_next.valid;
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= cell_next.id;
        delta_reg  <= cell_next.delta;
        period_reg <= cell_next.period;
    end

    assign entry = cur;

endmodule

@@ rtl/delta_list_timer_manager_core.sv @@
// Top level: delta-ordered timer queue built from a chain of list cells.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive kind, now_tick, delay_ticks, periodic and target_slot with
//   start high; the word is taken at a rising edge where busy is low. busy falls with
//   the edge that puts out the command's final word; an unknown kind never raises it.
//   Result channel: each result word sits on event_res, slot and last for one cycle
//   with strobe high; last marks the final word of a command. The receiver cannot
//   stall, so results leave as they are produced.
// Sequencing
//   An unknown kind is answered at the accepting edge. Stop is answered from ST_STOP,
//   create with no free slot from ST_ELAPSED. Create passes ST_ELAPSED and ST_ADD, then
//   ST_WALK steps past list entries (up to SLOTS-1), one entry per cycle, and inserts.
//   Advance passes ST_ELAPSED, then ST_ADV puts out one word per expiry, and each
//   reloaded periodic timer is placed by ST_WALK. Commands are handled one at a time.
// Reset
//   rst_n clears the list (all cells invalid), the tick bookkeeping and the FSM;
//   commands are taken from the first edge after reset is released.
module delta_list_timer_manager_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] now_tick,
    input  logic [31:0] delay_ticks,
    input  logic        periodic,
    input  logic [3:0]  target_slot,
    output logic        strobe,
    output logic [2:0]  event_res,
    output logic [3:0]  slot,
    output logic        last
);

    localparam int SW = dltm_pkg::SLOT_W;
    localparam int FW = dltm_pkg::FIRE_W;

    // list cells, index 0 is the head; each cell carries its reload period
    dltm_pkg::cell_t     cells [dltm_pkg::SLOTS];
    dltm_pkg::cell_t     cell_prev [dltm_pkg::SLOTS];
    dltm_pkg::cell_t     cell_nxt  [dltm_pkg::SLOTS];
    dltm_pkg::cell_cmd_t cmd;

    dltm_pkg::state_t state_reg, state_next;

    logic [1:0]    kind_reg;
    logic [31:0]   now_reg, delay_reg;
    logic          periodic_reg;
    logic [SW-1:0] target_reg;
    logic [31:0]   last_tick_reg, last_tick_next;
    logic [31:0]   pending_reg, pending_next;
    logic [31:0]   el_reg, el_next;
    logic [31:0]   d_reg, d_next;
    logic [31:0]   ins_per_reg, ins_per_next;
    logic [SW-1:0] ins_id_reg, ins_id_next;
    logic          ins_adv_reg, ins_adv_next;
    logic [SW-1:0] walk_reg, walk_next;
    logic [FW-1:0] fires_reg, fires_next;

    logic          strobe_reg, strobe_next;
    logic [2:0]    ev_reg, ev_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          last_reg, last_next;

    logic [dltm_pkg::SLOTS-1:0] slot_used;
    logic [dltm_pkg::SLOTS-1:0] cell_valid;
    logic                       free_found;
    logic [SW-1:0]              free_slot;
    logic [SW-1:0]              match_pos;
    dltm_pkg::cell_t            walk_cell;
    dltm_pkg::cell_t            head;
    logic [31:0]                head_reload;

    // chain wiring
    genvar g;
    generate
        for (g = 0; g < dltm_pkg::SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign cell_prev[g] = '0;
            end
            else
            begin : g_mid
                assign cell_prev[g] = cells[g-1];
            end
            if (g == dltm_pkg::SLOTS - 1)
            begin : g_last
                assign cell_nxt[g] = '0;
            end
            else
            begin : g_tail
                assign cell_nxt[g] = cells[g+1];
            end
            dltm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (SW'(g)),
                .cmd       (cmd),
                .prev_cell (cell_prev[g]),
                .next_cell (cell_nxt[g]),
                .entry     (cells[g])
            );
            assign cell_valid[g] = cells[g].valid;
        end
    endgenerate

    // slot occupancy, lowest free slot, position of the stop target
    always_comb
    begin
        slot_used  = '0;
        free_found = 1'b0;
        free_slot  = '0;
        match_pos  = '0;
        for (int c = 0; c < dltm_pkg::SLOTS; c++)
        begin
            if (cells[c].valid)
                slot_used[cells[c].id] = 1'b1;
            if (cells[c].valid && cells[c].id == target_reg)
                match_pos = SW'(c);
        end
        for (int s = dltm_pkg::SLOTS - 1; s >= 0; s--)
        begin
            if (!slot_used[s])
            begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    assign walk_cell   = cells[walk_reg];
    assign head        = cells[0];
    assign head_reload = head.period;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dltm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == dltm_pkg::KIND_STOP)
                        state_next = dltm_pkg::ST_STOP;
                    else if (kind == dltm_pkg::KIND_CREATE || kind == dltm_pkg::KIND_ADVANCE)
                        state_next = dltm_pkg::ST_ELAPSED;
                end
            end
            dltm_pkg::ST_ELAPSED:
            begin
                if (kind_reg == dltm_pkg::KIND_ADVANCE)
                    state_next = dltm_pkg::ST_ADV;
                else if (free_found)
                    state_next = dltm_pkg::ST_ADD;
                else
                    state_next = dltm_pkg::ST_IDLE;
            end
            dltm_pkg::ST_ADD:
            begin
                state_next = dltm_pkg::ST_WALK;
            end
            dltm_pkg::ST_WALK:
            begin
                if (!walk_cell.valid || d_reg < walk_cell.delta)
                    state_next = ins_adv_reg ? dltm_pkg::ST_ADV : dltm_pkg::ST_IDLE;
            end
            dltm_pkg::ST_STOP:
            begin
                state_next = dltm_pkg::ST_IDLE;
            end
            dltm_pkg::ST_ADV:
            begin
                if (!head.valid || fires_reg == FW'(dltm_pkg::MAX_FIRES) || head.delta > el_reg)
                    state_next = dltm_pkg::ST_IDLE;
                else if (head_reload != '0)
                    state_next = dltm_pkg::ST_WALK;
            end
            default:
            begin
                state_next = dltm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, cell commands and result words
    always_comb
    begin
        cmd            = '0;
        cmd.op         = dltm_pkg::OP_HOLD;
        last_tick_next = last_tick_reg;
        pending_next   = pending_reg;
        el_next        = el_reg;
        d_next         = d_reg;
        ins_per_next   = ins_per_reg;
        ins_id_next    = ins_id_reg;
        ins_adv_next   = ins_adv_reg;
        walk_next      = walk_reg;
        fires_next     = fires_reg;
        strobe_next    = 1'b0;
        ev_next        = ev_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        case (state_reg)
            dltm_pkg::ST_IDLE:
            begin
                if (start && kind == dltm_pkg::KIND_UNKNOWN)
                begin
                    strobe_next = 1'b1;
                    ev_next     = dltm_pkg::EV_DONE;
                    slot_next   = '0;
                    last_next   = 1'b1;
                end
            end
            dltm_pkg::ST_ELAPSED:
            begin
                el_next    = dltm_pkg::sat_add(pending_reg, now_reg - last_tick_reg);
                fires_next = '0;
                if (kind_reg == dltm_pkg::KIND_ADVANCE)
                    last_tick_next = now_reg;
                else if (free_found)
                begin
                    ins_per_next = periodic_reg ? delay_reg : '0;
                    ins_id_next  = free_slot;
                    ins_adv_next = 1'b0;
                end
                else
                begin
                    strobe_next = 1'b1;
                    ev_next     = dltm_pkg::EV_NO_SLOT;
                    slot_next   = '0;
                    last_next   = 1'b1;
                end
            end
            dltm_pkg::ST_ADD:
            begin
                d_next    = dltm_pkg::sat_add(delay_reg, el_reg);
                walk_next = '0;
            end
            dltm_pkg::ST_WALK:
            begin
                if (!walk_cell.valid || d_reg < walk_cell.delta)
                begin
                    cmd.op  = dltm_pkg::OP_INSERT;
                    cmd.pos = walk_reg;
                    cmd.id  = ins_id_reg;
                    cmd.d   = d_reg;
                    cmd.per = ins_per_reg;
                    if (!ins_adv_reg)
                    begin
                        strobe_next = 1'b1;
                        ev_next     = dltm_pkg::EV_CREATED;
                        slot_next   = ins_id_reg;
                        last_next   = 1'b1;
                    end
                end
                else
                begin
                    d_next    = d_reg - walk_cell.delta;
                    walk_next = walk_reg + 1'b1;
                end
            end
            dltm_pkg::ST_STOP:
            begin
                strobe_next = 1'b1;
                slot_next   = target_reg;
                last_next   = 1'b1;
                if (slot_used[target_reg])
                begin
                    cmd.op   = dltm_pkg::OP_REMOVE;
                    cmd.pos  = match_pos;
                    cmd.fold = 1'b1;
                    ev_next  = dltm_pkg::EV_STOPPED;
                end
                else
                    ev_next  = dltm_pkg::EV_INACTIVE;
            end
            dltm_pkg::ST_ADV:
            begin
                if (!head.valid || fires_reg == FW'(dltm_pkg::MAX_FIRES))
                begin
                    // leftover ticks stay pending only while timers remain
                    pending_next = head.valid ? el_reg : '0;
                    strobe_next  = 1'b1;
                    ev_next      = dltm_pkg::EV_DONE;
                    slot_next    = '0;
                    last_next    = 1'b1;
                end
                else if (head.delta > el_reg)
                begin
                    cmd.op       = dltm_pkg::OP_SUB;
                    cmd.d        = el_reg;
                    pending_next = '0;
                    strobe_next  = 1'b1;
                    ev_next      = dltm_pkg::EV_DONE;
                    slot_next    = '0;
                    last_next    = 1'b1;
                end
                else
                begin
                    // fire the head, drop it, re-insert if periodic
                    el_next      = el_reg - head.delta;
                    fires_next   = fires_reg + 1'b1;
                    cmd.op       = dltm_pkg::OP_REMOVE;
                    cmd.pos      = '0;
                    strobe_next  = 1'b1;
                    ev_next      = dltm_pkg::EV_EXPIRED;
                    slot_next    = head.id;
                    last_next    = 1'b0;
                    d_next       = head_reload;
                    ins_per_next = head_reload;
                    ins_id_next  = head.id;
                    ins_adv_next = 1'b1;
                    walk_next    = '0;
                end
            end
            default:
            begin
                cmd.op = dltm_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dltm_pkg::ST_IDLE;
            last_tick_reg <= '0;
            pending_reg   <= '0;
            strobe_reg    <= 1'b0;
            fires_reg     <= '0;
            ins_adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            pending_reg   <= pending_next;
            strobe_reg    <= strobe_next;
            fires_reg     <= fires_next;
            ins_adv_reg   <= ins_adv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dltm_pkg::ST_IDLE && start)
        begin
            kind_reg     <= kind;
            now_reg      <= now_tick;
            delay_reg    <= delay_ticks;
            periodic_reg <= periodic;
            target_reg   <= target_slot;
        end
        el_reg      <= el_next;
        d_reg       <= d_next;
        ins_per_reg <= ins_per_next;
        ins_id_reg  <= ins_id_next;
        walk_reg    <= walk_next;
        ev_reg      <= ev_next;
        slot_reg    <= slot_next;
        last_reg    <= last_next;
    end

    assign busy      = (state_reg != dltm_pkg::ST_IDLE);
    assign strobe    = strobe_reg;
    assign event_res = ev_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

`ifndef SYNTH
    // final word of a command leaves the FSM idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> state_reg == dltm_pkg::ST_IDLE)
        else $error("last word while command still running");

    // an empty head means an empty list
    a_list_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !cells[0].valid |-> cell_valid == '0)
        else $error("list cells not packed toward the head");

    // expiry count never passes the limit
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FW'(dltm_pkg::MAX_FIRES))
        else $error("expiry count beyond limit");

    // an expiry word is never the final word
    a_expire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && ev_reg == dltm_pkg::EV_EXPIRED |-> !last_reg)
        else $error("expiry marked as final word");
`endif

endmodule
